// ----- rtl/sdspi_pkg.sv -----
// Shared types and constants for the SD card SPI-mode host.
// No dependencies.
package sdspi_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int WAKE_BYTES = 10;

	localparam logic [2:0] FN_REPLY = 3'd0;
	localparam logic [2:0] FN_INIT = 3'd1;
	localparam logic [2:0] FN_READ = 3'd2;
	localparam logic [2:0] FN_WRITE = 3'd3;
	localparam logic [2:0] FN_WBYTE = 3'd4;

	localparam logic [1:0] KD_BUS = 2'd0;
	localparam logic [1:0] KD_RDATA = 2'd1;
	localparam logic [1:0] KD_WWANT = 2'd2;
	localparam logic [1:0] KD_DONE = 2'd3;

	localparam logic [1:0] REG_RESET_RETRY = 2'd0;
	localparam logic [1:0] REG_READY_RETRY = 2'd1;
	localparam logic [1:0] REG_POLL = 2'd2;
	localparam logic [1:0] REG_TOKEN = 2'd3;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  rx_byte;
		logic [31:0] block_addr;
		logic [7:0]  wr_byte;
	} in_req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tx_byte;
		logic       chip_select_low;
		logic [7:0] read_byte;
		logic [2:0] status;
		logic       high_capacity;
		logic       last_of_run;
	} out_req_t;

	// one step of the sequencer: up to two results
	typedef struct packed {
		logic     two;
		out_req_t r0;
		out_req_t r1;
	} step_t;

	typedef struct packed {
		logic [7:0]  reset_retry_limit;
		logic [15:0] ready_retry_limit;
		logic [7:0]  response_poll_limit;
		logic [15:0] token_wait_limit;
	} cfg_t;

endpackage

// ----- rtl/sd_card_spi_host_unit.sv -----
// Top level of the SD card SPI-mode host: config registers, front and back.
// Uses sdspi_pkg, sdspi_front, sdspi_back.
//  channel | dir | handshake        | payload
//  in      | in  | in_valid/in_stall   | in_req_t
//  out     | out | out_valid/out_stall | out_req_t
//  cfg     | in  | cfg_we, cfg_index   | cfg_data
// One request per cycle while results drain; a request that gives two results
// holds the next until its second result is leaving (two-slot result stage).
// Reset clears the sequencer to idle and the limits to their defaults.
// A stall on the output backs up through a one-entry front register.
module sd_card_spi_host_unit import sdspi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_req_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_req_t    out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	cfg_t    cfg_q;
	logic    q_valid, q_stall;
	in_req_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{reset_retry_limit: 8'd200, ready_retry_limit: 16'hFFFF,
				response_poll_limit: 8'd255, token_wait_limit: 16'hFFFF};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RESET_RETRY: cfg_q.reset_retry_limit <= cfg_data[7:0];
				REG_READY_RETRY: cfg_q.ready_retry_limit <= cfg_data;
				REG_POLL: cfg_q.response_poll_limit <= cfg_data[7:0];
				default: cfg_q.token_wait_limit <= cfg_data;
			endcase
		end
	end

	sdspi_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.q_valid, .q_stall, .q_data
	);

	sdspi_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_valid, .q_stall, .q_data,
		.out_valid, .out_stall, .out_data
	);
endmodule

// ----- rtl/sdspi_front.sv -----
// Front part: takes input requests and drops those with undefined func codes
// (above FN_WBYTE), which the sequencer would take as write bytes. Uses sdspi_pkg.
module sdspi_front import sdspi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  in_req_t in_data,
	output logic    q_valid,
	input  logic    q_stall,
	output in_req_t q_data
);
	logic    full_q;
	in_req_t data_q;
	logic    keep;

	assign keep = in_data.func <= FN_WBYTE;
	assign in_stall = full_q && q_stall;
	assign q_valid = full_q;
	assign q_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (!in_stall) begin
			full_q <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_q <= in_data;
		end
	end
endmodule

// ----- rtl/sdspi_back.sv -----
// Back part: the SPI-mode protocol sequencer, one request per cycle unless the
// two-entry result stage stalls it. Uses sdspi_pkg.
module sdspi_back import sdspi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     q_valid,
	output logic     q_stall,
	input  in_req_t  q_data,
	output logic     out_valid,
	input  logic     out_stall,
	output out_req_t out_data
);
	localparam logic [5:0] PH_IDLE = 6'd0;
	localparam logic [5:0] PH_WAKE = 6'd1;
	localparam logic [5:0] PH_TAIL = 6'd22;
	localparam logic [5:0] PH_R7 = 6'd23;
	localparam logic [5:0] PH_OCR = 6'd24;
	localparam logic [5:0] PH_TOKEN = 6'd25;
	localparam logic [5:0] PH_RDATA = 6'd26;
	localparam logic [5:0] PH_RCRC = 6'd27;
	localparam logic [5:0] PH_WTOKEN = 6'd28;
	localparam logic [5:0] PH_WWANT = 6'd29;
	localparam logic [5:0] PH_WDATA = 6'd30;
	localparam logic [5:0] PH_WCRC = 6'd31;
	localparam logic [5:0] PH_WRESP = 6'd32;
	localparam logic [5:0] PH_BUSY = 6'd33;

	localparam logic [1:0] CK_UNKNOWN = 2'd0;
	localparam logic [1:0] CK_SDSC = 2'd1;
	localparam logic [1:0] CK_SDHC = 2'd2;

	localparam logic [9:0] BLK_LAST = 10'(BLOCK_BYTES - 1);

	function automatic logic [5:0] ph_send(input logic [3:0] s);
		ph_send = 6'd2 + {1'b0, s, 1'b0};
	endfunction

	function automatic logic [7:0] frame_byte(input logic [3:0] s, input logic [2:0] idx,
		input logic [31:0] taddr);
		logic [5:0]  code;
		logic [31:0] arg;
		logic [7:0]  crc;
		begin
			unique case (s)
				4'd0: begin code = 6'd0; arg = 32'h0; crc = 8'h95; end
				4'd1: begin code = 6'd8; arg = 32'h000001AA; crc = 8'h87; end
				4'd2: begin code = 6'd55; arg = 32'h0; crc = 8'h65; end
				4'd3: begin code = 6'd41; arg = 32'h40000000; crc = 8'h77; end
				4'd4: begin code = 6'd55; arg = 32'h0; crc = 8'h65; end
				4'd5: begin code = 6'd41; arg = 32'h0; crc = 8'hFF; end
				4'd6: begin code = 6'd58; arg = 32'h0; crc = 8'hFF; end
				4'd7: begin code = 6'd16; arg = 32'(BLOCK_BYTES); crc = 8'hFF; end
				4'd8: begin code = 6'd17; arg = taddr; crc = 8'hFF; end
				default: begin code = 6'd24; arg = taddr; crc = 8'hFF; end
			endcase
			unique case (idx)
				3'd1: frame_byte = {2'b01, code};
				3'd2: frame_byte = arg[31:24];
				3'd3: frame_byte = arg[23:16];
				3'd4: frame_byte = arg[15:8];
				3'd5: frame_byte = arg[7:0];
				default: frame_byte = crc;
			endcase
		end
	endfunction

	logic [5:0]  phase_q;
	logic [9:0]  bcnt_q;
	logic [15:0] retry_q;
	logic [7:0]  poll_q;
	logic [1:0]  ckind_q;
	logic [31:0] taddr_q;
	logic [31:0] reply_q;
	logic [7:0]  lresp_q;

	logic [5:0]  phase_d;
	logic [9:0]  bcnt_d;
	logic [15:0] retry_d;
	logic [7:0]  poll_d;
	logic [1:0]  ckind_d;
	logic [31:0] taddr_d;
	logic [31:0] reply_d;
	logic [7:0]  lresp_d;

	out_req_t    res [2];
	logic [1:0]  nres;
	step_t       st;

	// result stage: two slots, front slot presented
	out_req_t    buf0_q, buf1_q;
	logic [1:0]  cnt_q;
	logic        take;
	logic        pop;

	always_comb begin
		logic [3:0]  slot;
		logic [7:0]  rx;
		logic [15:0] rinc;
		logic [31:0] rb;
		out_req_t    r;
		phase_d = phase_q; bcnt_d = bcnt_q; retry_d = retry_q; poll_d = poll_q;
		ckind_d = ckind_q; taddr_d = taddr_q; reply_d = reply_q; lresp_d = lresp_q;
		nres = 2'd0;
		res[0] = '0;
		res[1] = '0;
		rx = q_data.rx_byte;
		slot = 4'(({2'b0, phase_q} - 8'd2) >> 1);
		rinc = retry_q + 16'd1;
		rb = {reply_q[23:0], rx};
		r = '0;

		// helpers written out inline as small groups of assignments
		unique case (1'b1)
			(q_data.func == FN_REPLY): begin
				if (phase_q >= 6'd2 && phase_q < PH_TAIL) begin
					if (!phase_q[0]) begin
						if (bcnt_q <= 10'd6) begin
							r.kind = KD_BUS; r.chip_select_low = 1'b1;
							r.tx_byte = frame_byte(slot, bcnt_q[2:0], taddr_q);
							res[0] = r; nres = 2'd1;
							bcnt_d = bcnt_q + 10'd1;
						end else begin
							phase_d = phase_q + 6'd1; poll_d = 8'd1;
							res[0] = '{kind: KD_BUS, tx_byte: 8'hFF, chip_select_low: 1'b1,
								default: '0};
							nres = 2'd1;
						end
					end else if (rx[7] && poll_q < cfg.response_poll_limit) begin
						poll_d = poll_q + 8'd1;
						res[0] = '{kind: KD_BUS, tx_byte: 8'hFF, chip_select_low: 1'b1,
							default: '0};
						nres = 2'd1;
					end else begin
						// command response
						lresp_d = rx;
						nres = 2'd1;
						res[0] = '{kind: KD_BUS, tx_byte: 8'hFF, default: '0};
						res[1] = '{kind: KD_DONE, default: '0};
						case (slot)
							4'd0: begin
								retry_d = rinc;
								if (rx == 8'h01) begin
									bcnt_d = 10'd1; phase_d = PH_TAIL;
								end else if (rinc >= {8'd0, cfg.reset_retry_limit}) begin
									nres = 2'd2; res[1].status = 3'd1; phase_d = PH_IDLE;
								end else begin
									bcnt_d = 10'd0; phase_d = PH_TAIL;
								end
							end
							4'd1: begin
								retry_d = 16'd0;
								res[0].chip_select_low = 1'b1;
								bcnt_d = 10'd0;
								if (rx == 8'h01) begin
									phase_d = PH_R7; reply_d = '0;
								end else begin
									phase_d = ph_send(4'd4); bcnt_d = 10'd1; poll_d = 8'd0;
								end
							end
							4'd2, 4'd4: begin
								res[0].chip_select_low = 1'b1;
								phase_d = ph_send(slot + 4'd1); bcnt_d = 10'd1; poll_d = 8'd0;
							end
							4'd3, 4'd5: begin
								retry_d = rinc;
								if (rx == 8'h00) begin
									phase_d = PH_TAIL;
									if (slot == 4'd3) begin
										bcnt_d = 10'd6;
									end else begin
										ckind_d = CK_SDSC; bcnt_d = 10'd7;
									end
								end else if (rinc >= cfg.ready_retry_limit) begin
									nres = 2'd2; phase_d = PH_IDLE;
									res[1].status = (slot == 4'd3) ? 3'd2 : 3'd3;
								end else begin
									phase_d = PH_TAIL; bcnt_d = 10'(slot - 4'd1);
								end
							end
							4'd6: begin
								res[0].chip_select_low = 1'b1;
								phase_d = PH_OCR; bcnt_d = 10'd0; reply_d = '0;
							end
							4'd7: begin
								nres = 2'd2; phase_d = PH_IDLE;
							end
							default: begin
								if (rx != 8'h00) begin
									nres = 2'd2; res[1].status = 3'd5; phase_d = PH_IDLE;
								end else if (slot == 4'd8) begin
									res[0].chip_select_low = 1'b1;
									phase_d = PH_TOKEN; retry_d = 16'd1;
								end else begin
									res[0].chip_select_low = 1'b1; res[0].tx_byte = 8'hFE;
									phase_d = PH_WTOKEN;
								end
							end
						endcase
					end
				end else begin
					res[0] = '{kind: KD_BUS, tx_byte: 8'hFF, chip_select_low: 1'b1,
						default: '0};
					res[1] = '{kind: KD_DONE, default: '0};
					case (phase_q)
						PH_WAKE: begin
							nres = 2'd1;
							if (bcnt_q < 10'(WAKE_BYTES)) begin
								bcnt_d = bcnt_q + 10'd1; res[0].chip_select_low = 1'b0;
							end else begin
								retry_d = '0; phase_d = ph_send(4'd0);
								bcnt_d = 10'd1; poll_d = 8'd0;
							end
						end
						PH_TAIL: begin
							nres = 2'd1;
							phase_d = ph_send((bcnt_q < 10'd10) ? bcnt_q[3:0] : 4'd0);
							bcnt_d = 10'd1; poll_d = 8'd0;
						end
						PH_R7, PH_OCR: begin
							reply_d = rb; bcnt_d = bcnt_q + 10'd1; nres = 2'd1;
							if (bcnt_q + 10'd1 >= 10'd4) begin
								res[0].chip_select_low = 1'b0;
								if (phase_q == PH_R7) begin
									if (rb[15:8] != 8'h01 || rb[7:0] != 8'hAA) begin
										nres = 2'd2; res[1].status = 3'd4; phase_d = PH_IDLE;
									end else begin
										retry_d = '0; bcnt_d = 10'd2; phase_d = PH_TAIL;
									end
								end else begin
									if (lresp_q == 8'h00) begin
										ckind_d = rb[30] ? CK_SDHC : CK_SDSC;
									end
									if (ckind_d == CK_SDSC) begin
										bcnt_d = 10'd7; phase_d = PH_TAIL;
									end else begin
										nres = 2'd2; phase_d = PH_IDLE;
									end
								end
							end
						end
						PH_TOKEN: begin
							nres = 2'd1;
							if (rx == 8'hFE) begin
								phase_d = PH_RDATA; bcnt_d = '0;
							end else if (retry_q >= cfg.token_wait_limit) begin
								nres = 2'd2; res[0].chip_select_low = 1'b0;
								res[1].status = 3'd6; phase_d = PH_IDLE;
							end else begin
								retry_d = rinc;
							end
						end
						PH_RDATA: begin
							nres = 2'd2;
							res[1] = res[0];
							res[0] = '{kind: KD_RDATA, read_byte: rx, default: '0};
							bcnt_d = bcnt_q + 10'd1;
							if (bcnt_q == BLK_LAST) begin
								phase_d = PH_RCRC; bcnt_d = '0;
							end
						end
						PH_RCRC: begin
							nres = 2'd1; bcnt_d = bcnt_q + 10'd1;
							if (bcnt_q != 10'd0) begin
								nres = 2'd2; res[0].chip_select_low = 1'b0; phase_d = PH_IDLE;
							end
						end
						PH_WTOKEN: begin
							nres = 2'd1; phase_d = PH_WWANT; bcnt_d = '0;
							res[0] = '{kind: KD_WWANT, default: '0};
						end
						PH_WDATA: begin
							nres = 2'd1; bcnt_d = bcnt_q + 10'd1;
							if (bcnt_q != BLK_LAST) begin
								phase_d = PH_WWANT; res[0] = '{kind: KD_WWANT, default: '0};
							end else begin
								phase_d = PH_WCRC; bcnt_d = '0;
							end
						end
						PH_WCRC: begin
							nres = 2'd1; bcnt_d = bcnt_q + 10'd1;
							if (bcnt_q != 10'd0) phase_d = PH_WRESP;
						end
						PH_WRESP: begin
							nres = 2'd1;
							if (rx[4:0] != 5'h05) begin
								nres = 2'd2; res[0].chip_select_low = 1'b0;
								res[1].status = 3'd7; phase_d = PH_IDLE;
							end else begin
								phase_d = PH_BUSY;
							end
						end
						PH_BUSY: begin
							nres = 2'd1;
							if (rx != 8'h00) begin
								nres = 2'd2; res[0].chip_select_low = 1'b0; phase_d = PH_IDLE;
							end
						end
						default: nres = 2'd0;
					endcase
				end
			end
			(q_data.func == FN_INIT): begin
				if (phase_q == PH_IDLE) begin
					phase_d = PH_WAKE; bcnt_d = 10'd1; nres = 2'd1;
					res[0] = '{kind: KD_BUS, tx_byte: 8'hFF, default: '0};
				end
			end
			(q_data.func == FN_READ || q_data.func == FN_WRITE): begin
				if (phase_q == PH_IDLE) begin
					taddr_d = (ckind_q == CK_SDSC) ? {q_data.block_addr[22:0], 9'd0}
						: q_data.block_addr;
					phase_d = ph_send(q_data.func[0] ? 4'd9 : 4'd8);
					bcnt_d = 10'd1; poll_d = 8'd0; nres = 2'd1;
					res[0] = '{kind: KD_BUS, tx_byte: 8'hFF, chip_select_low: 1'b1,
						default: '0};
				end
			end
			default: begin
				if (phase_q == PH_WWANT) begin
					phase_d = PH_WDATA; nres = 2'd1;
					res[0] = '{kind: KD_BUS, tx_byte: q_data.wr_byte, chip_select_low: 1'b1,
						default: '0};
				end
			end
		endcase
		res[0].high_capacity = (ckind_d == CK_SDHC);
		res[1].high_capacity = (ckind_d == CK_SDHC);
		res[0].last_of_run = (nres == 2'd1);
		res[1].last_of_run = 1'b1;
		st = '{two: (nres == 2'd2), r0: res[0], r1: res[1]};
	end

	// accept a new request only when the result stage can hold two more
	assign pop = (cnt_q != 2'd0) && !out_stall;
	assign q_stall = (cnt_q != 2'd0) && !(cnt_q == 2'd1 && pop) && !(cnt_q == 2'd2 && 1'b0);
	assign take = q_valid && !q_stall;
	assign out_valid = cnt_q != 2'd0;
	assign out_data = buf0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; bcnt_q <= '0; retry_q <= '0; poll_q <= '0;
			ckind_q <= CK_UNKNOWN; taddr_q <= '0; reply_q <= '0; lresp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (take) begin
				phase_q <= phase_d; bcnt_q <= bcnt_d; retry_q <= retry_d; poll_q <= poll_d;
				ckind_q <= ckind_d; taddr_q <= taddr_d; reply_q <= reply_d; lresp_q <= lresp_d;
			end
			if (take && nres != 2'd0) begin
				cnt_q <= nres;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && nres != 2'd0) begin
			buf0_q <= st.r0;
			buf1_q <= st.r1;
		end else if (pop) begin
			buf0_q <= buf1_q;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("result count out of range");
	a_no_take_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !take) else $error("request taken with results pending");
	a_wwant_nobus: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q == PH_WWANT && q_data.func == FN_REPLY) |-> nres == 2'd0)
		else $error("reply consumed while waiting for write byte");
endmodule

// ----- tb/tb_sd_card_spi_host_unit.sv -----
// Testbench for the SD card SPI-mode host: drives requests and plays the card side.
// Predicts each result in its own protocol sequencer and checks it field by field.
// Depends on sdspi_pkg and sd_card_spi_host_unit.
`timescale 1ns / 100ps

module tb_sd_card_spi_host_unit;
	import sdspi_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 250;

	localparam logic [2:0] FN_RSVD_LO = 3'd5;
	localparam logic [2:0] FN_RSVD_HI = 3'd7;

	// sequencer phases
	localparam int P_IDLE = 0;
	localparam int P_WAKE = 1;
	localparam int P_SEND0 = 2;
	localparam int P_TAIL = 22;
	localparam int P_R7 = 23;
	localparam int P_OCR = 24;
	localparam int P_TOKEN = 25;
	localparam int P_RDATA = 26;
	localparam int P_RCRC = 27;
	localparam int P_WTOKEN = 28;
	localparam int P_WWANT = 29;
	localparam int P_WDATA = 30;
	localparam int P_WCRC = 31;
	localparam int P_WRESP = 32;
	localparam int P_BUSY = 33;

	// command slots
	localparam int SL_CMD0 = 0;
	localparam int SL_CMD8 = 1;
	localparam int SL_CMD55_V2 = 2;
	localparam int SL_ACMD41_V2 = 3;
	localparam int SL_CMD55_V1 = 4;
	localparam int SL_ACMD41_V1 = 5;
	localparam int SL_CMD58 = 6;
	localparam int SL_CMD16 = 7;
	localparam int SL_CMD17 = 8;
	localparam int SL_CMD24 = 9;

	localparam logic [2:0] S_OK = 3'd0;
	localparam logic [2:0] S_NO_IDLE = 3'd1;
	localparam logic [2:0] S_V2_TIMEOUT = 3'd2;
	localparam logic [2:0] S_V1_TIMEOUT = 3'd3;
	localparam logic [2:0] S_ECHO = 3'd4;
	localparam logic [2:0] S_REJECT = 3'd5;
	localparam logic [2:0] S_TOKEN = 3'd6;
	localparam logic [2:0] S_DATA_REJ = 3'd7;

	typedef enum logic [1:0] {CK_UNKNOWN = 2'd0, CK_SDSC = 2'd1, CK_SDHC = 2'd2} card_kind_e;

	bit clk = 0;
	logic arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	in_req_t in_data;
	out_req_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	sd_card_spi_host_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// predicted sequencer state
	int ph = P_IDLE;
	int bcnt = 0;
	logic [1:0] op = 2'd0;
	logic [15:0] retries = 0;
	logic [7:0] polls = 0;
	card_kind_e ck = CK_UNKNOWN;
	logic [31:0] target = 0, reply = 0;
	logic [7:0] last_resp = 0;
	logic [7:0] lim_reset = 8'd200, lim_poll = 8'd255;
	logic [15:0] lim_ready = 16'hFFFF, lim_token = 16'hFFFF;

	out_req_t step_buf[2];
	int step_n;
	out_req_t pending_q[$];

	int errors = 0;
	int got_cnt = 0;
	int idle_cycles = 0;
	bit calm = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic void put_res(logic [1:0] k, logic [7:0] tx, logic cs, logic [7:0] rd,
			logic [2:0] st);
		if (step_n >= 2)
			return;
		step_buf[step_n] = '{kind: k, tx_byte: tx, chip_select_low: cs, read_byte: rd,
			status: st, high_capacity: 1'b0, last_of_run: 1'b0};
		step_n++;
	endfunction

	function automatic void bus(logic [7:0] b, logic cs);
		put_res(KD_BUS, b, cs, 8'h00, S_OK);
	endfunction

	function automatic void tail_finish(logic [2:0] st);
		bus(8'hFF, 1'b0);
		ph = P_IDLE;
		op = 2'd0;
		put_res(KD_DONE, 8'h00, 1'b0, 8'h00, st);
	endfunction

	function automatic void tail_then(int slot);
		bcnt = slot;
		ph = P_TAIL;
		bus(8'hFF, 1'b0);
	endfunction

	function automatic void start_cmd(int slot);
		ph = P_SEND0 + 2 * slot;
		bcnt = 1;
		polls = 0;
		bus(8'hFF, 1'b1);
	endfunction

	function automatic void begin_four(int next_ph);
		ph = next_ph;
		bcnt = 0;
		reply = 0;
		bus(8'hFF, 1'b1);
	endfunction

	function automatic logic [7:0] frame_byte(int slot, int idx);
		logic [5:0] code;
		logic [31:0] arg;
		logic [7:0] crc;
		arg = 32'h0;
		crc = 8'hFF;
		case (slot)
			SL_CMD0: begin code = 6'd0; crc = 8'h95; end
			SL_CMD8: begin code = 6'd8; arg = 32'h0000_01AA; crc = 8'h87; end
			SL_CMD55_V2: begin code = 6'd55; crc = 8'h65; end
			SL_ACMD41_V2: begin code = 6'd41; arg = 32'h4000_0000; crc = 8'h77; end
			SL_CMD55_V1: begin code = 6'd55; crc = 8'h65; end
			SL_ACMD41_V1: code = 6'd41;
			SL_CMD58: code = 6'd58;
			SL_CMD16: begin code = 6'd16; arg = BLOCK_BYTES; end
			SL_CMD17: begin code = 6'd17; arg = target; end
			default: begin code = 6'd24; arg = target; end
		endcase
		case (idx)
			1: return {2'b01, code};
			2: return arg[31:24];
			3: return arg[23:16];
			4: return arg[15:8];
			5: return arg[7:0];
			default: return crc;
		endcase
	endfunction

	function automatic void on_response(int slot, logic [7:0] r);
		last_resp = r;
		case (slot)
			SL_CMD0: begin
				retries++;
				if (r == 8'h01) tail_then(SL_CMD8);
				else if (retries >= lim_reset) tail_finish(S_NO_IDLE);
				else tail_then(SL_CMD0);
			end
			SL_CMD8: begin
				retries = 0;
				if (r == 8'h01) begin_four(P_R7);
				else start_cmd(SL_CMD55_V1);
			end
			SL_CMD55_V2: start_cmd(SL_ACMD41_V2);
			SL_CMD55_V1: start_cmd(SL_ACMD41_V1);
			SL_ACMD41_V2, SL_ACMD41_V1: begin
				retries++;
				if (r == 8'h00) begin
					if (slot == SL_ACMD41_V2) begin
						tail_then(SL_CMD58);
					end else begin
						ck = CK_SDSC;
						tail_then(SL_CMD16);
					end
				end else if (retries >= lim_ready) begin
					tail_finish(slot == SL_ACMD41_V2 ? S_V2_TIMEOUT : S_V1_TIMEOUT);
				end else begin
					tail_then(slot - 1);
				end
			end
			SL_CMD58: begin_four(P_OCR);
			SL_CMD16: tail_finish(S_OK);
			SL_CMD17: begin
				if (r != 8'h00) begin
					tail_finish(S_REJECT);
				end else begin
					ph = P_TOKEN;
					retries = 1;
					bus(8'hFF, 1'b1);
				end
			end
			default: begin
				if (r != 8'h00) begin
					tail_finish(S_REJECT);
				end else begin
					ph = P_WTOKEN;
					bus(8'hFE, 1'b1);
				end
			end
		endcase
	endfunction

	function automatic void on_reply(logic [7:0] rx);
		int slot;
		if (ph >= P_SEND0 && ph < P_TAIL) begin
			slot = (ph - P_SEND0) >> 1;
			if (((ph - P_SEND0) & 1) == 0) begin
				if (bcnt <= 6) begin
					bus(frame_byte(slot, bcnt), 1'b1);
					bcnt++;
				end else begin
					ph = ph + 1;
					polls = 1;
					bus(8'hFF, 1'b1);
				end
			end else if (rx[7] && polls < lim_poll) begin
				polls++;
				bus(8'hFF, 1'b1);
			end else begin
				on_response(slot, rx);
			end
			return;
		end
		case (ph)
			P_WAKE: begin
				if (bcnt < WAKE_BYTES) begin
					bcnt++;
					bus(8'hFF, 1'b0);
				end else begin
					retries = 0;
					start_cmd(SL_CMD0);
				end
			end
			P_TAIL: start_cmd(bcnt < 10 ? bcnt : SL_CMD0);
			P_R7, P_OCR: begin
				reply = {reply[23:0], rx};
				bcnt++;
				if (bcnt < 4) begin
					bus(8'hFF, 1'b1);
				end else if (ph == P_R7) begin
					if (reply[15:8] != 8'h01 || reply[7:0] != 8'hAA) begin
						tail_finish(S_ECHO);
					end else begin
						retries = 0;
						tail_then(SL_CMD55_V2);
					end
				end else begin
					if (last_resp == 8'h00)
						ck = reply[30] ? CK_SDHC : CK_SDSC;
					if (ck == CK_SDSC) tail_then(SL_CMD16);
					else tail_finish(S_OK);
				end
			end
			P_TOKEN: begin
				if (rx == 8'hFE) begin
					ph = P_RDATA;
					bcnt = 0;
					bus(8'hFF, 1'b1);
				end else if (retries >= lim_token) begin
					tail_finish(S_TOKEN);
				end else begin
					retries++;
					bus(8'hFF, 1'b1);
				end
			end
			P_RDATA: begin
				put_res(KD_RDATA, 8'h00, 1'b0, rx, S_OK);
				bcnt++;
				if (bcnt >= BLOCK_BYTES) begin
					ph = P_RCRC;
					bcnt = 0;
				end
				bus(8'hFF, 1'b1);
			end
			P_RCRC: begin
				bcnt++;
				if (bcnt < 2) bus(8'hFF, 1'b1);
				else tail_finish(S_OK);
			end
			P_WTOKEN: begin
				ph = P_WWANT;
				bcnt = 0;
				put_res(KD_WWANT, 8'h00, 1'b0, 8'h00, S_OK);
			end
			P_WDATA: begin
				bcnt++;
				if (bcnt < BLOCK_BYTES) begin
					ph = P_WWANT;
					put_res(KD_WWANT, 8'h00, 1'b0, 8'h00, S_OK);
				end else begin
					ph = P_WCRC;
					bcnt = 0;
					bus(8'hFF, 1'b1);
				end
			end
			P_WCRC: begin
				bcnt++;
				if (bcnt >= 2) ph = P_WRESP;
				bus(8'hFF, 1'b1);
			end
			P_WRESP: begin
				if (rx[4:0] != 5'h05) begin
					tail_finish(S_DATA_REJ);
				end else begin
					ph = P_BUSY;
					bus(8'hFF, 1'b1);
				end
			end
			P_BUSY: begin
				if (rx == 8'h00) bus(8'hFF, 1'b1);
				else tail_finish(S_OK);
			end
			default: ;
		endcase
	endfunction

	function automatic void predict_step(in_req_t it);
		step_n = 0;
		case (it.func)
			FN_REPLY: if (ph != P_IDLE && ph != P_WWANT) on_reply(it.rx_byte);
			FN_INIT: begin
				if (ph == P_IDLE) begin
					op = 2'd1;
					ph = P_WAKE;
					bcnt = 1;
					bus(8'hFF, 1'b0);
				end
			end
			FN_READ, FN_WRITE: begin
				if (ph == P_IDLE) begin
					op = it.func[1:0];
					target = (ck == CK_SDSC) ? (it.block_addr << 9) : it.block_addr;
					start_cmd(it.func == FN_READ ? SL_CMD17 : SL_CMD24);
				end
			end
			FN_WBYTE: begin
				if (ph == P_WWANT) begin
					ph = P_WDATA;
					bus(it.wr_byte, 1'b1);
				end
			end
			default: ;
		endcase
		for (int k = 0; k < step_n; k++) begin
			step_buf[k].high_capacity = (ck == CK_SDHC);
			step_buf[k].last_of_run = (k == step_n - 1);
		end
	endfunction

	// card side: mostly well-formed replies for the phase the host is in
	function automatic logic [7:0] card_reply();
		int r;
		int slot;
		r = $urandom_range(0, 9);
		if (ph >= P_SEND0 && ph < P_TAIL) begin
			slot = (ph - P_SEND0) >> 1;
			if (((ph - P_SEND0) & 1) == 0)
				return (r < 7) ? 8'hFF : 8'($urandom);
			if ($urandom_range(0, 9) < 4)
				return 8'h80 | 8'($urandom);
			case (slot)
				SL_CMD0: return (r < 7) ? 8'h01 : 8'($urandom);
				SL_CMD8: return (r < 6) ? 8'h01 : (r < 8) ? 8'h05 : 8'($urandom);
				SL_ACMD41_V2, SL_ACMD41_V1:
					return (r < 5) ? 8'h00 : (r < 8) ? 8'h01 : 8'($urandom);
				SL_CMD58: return (r < 8) ? 8'h00 : 8'($urandom);
				SL_CMD17, SL_CMD24: return (r < 9) ? 8'h00 : 8'($urandom);
				default: return 8'($urandom);
			endcase
		end
		case (ph)
			P_R7: begin
				if (r == 0) return 8'($urandom);
				return (bcnt == 2) ? 8'h01 : (bcnt == 3) ? 8'hAA : 8'($urandom);
			end
			P_TOKEN: return (r < 3) ? 8'hFE : (r < 9) ? 8'hFF : 8'($urandom);
			P_WRESP: return (r < 8) ? {3'($urandom), 5'h05} : 8'($urandom);
			P_BUSY: return (r < 6) ? 8'h00 : 8'($urandom);
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic in_req_t next_request();
		in_req_t it;
		int r;
		it.func = FN_REPLY;
		it.rx_byte = 8'($urandom);
		it.wr_byte = 8'($urandom);
		r = $urandom_range(0, 7);
		it.block_addr = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			it.func = 3'($urandom_range(0, 7));
		end else if (ph == P_IDLE) begin
			r = $urandom_range(0, 99);
			if (ck == CK_UNKNOWN) it.func = (r < 60) ? FN_INIT : (r < 80) ? FN_READ : FN_WRITE;
			else it.func = (r < 30) ? FN_INIT : (r < 65) ? FN_READ : FN_WRITE;
		end else if (ph == P_WWANT) begin
			it.func = FN_WBYTE;
		end else begin
			it.rx_byte = card_reply();
		end
		return it;
	endfunction

	task automatic send(input in_req_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic issue(input in_req_t it, input int typed_n, input out_req_t typed);
		predict_step(it);
		if (typed_n < 0) begin
			for (int k = 0; k < step_n; k++)
				pending_q.push_back(step_buf[k]);
		end else if (typed_n == 1) begin
			pending_q.push_back(typed);
		end
		send(it);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RESET_RETRY: lim_reset = val[7:0];
			REG_READY_RETRY: lim_ready = val;
			REG_POLL: lim_poll = val[7:0];
			default: lim_token = val;
		endcase
	endtask

	// result side: random stall bursts plus one long hold-off
	initial begin
		int hold;
		bit pressed;
		hold = 0;
		pressed = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!pressed && got_cnt >= 300) begin
				pressed = 1;
				hold = 400;
			end else if (hold == 0 && !calm && $urandom_range(0, 12) == 0) begin
				hold = $urandom_range(1, 11);
			end
			out_stall <= (hold > 0);
			if (hold > 0)
				hold--;
		end
	end

	always @(posedge clk) begin
		out_req_t want;
		if (arst_n && out_valid && !out_stall) begin
			got_cnt++;
			if (pending_q.size() == 0) begin
				report_mismatch("result with nothing pending");
			end else begin
				want = pending_q.pop_front();
				if (out_data.kind !== want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
				if (out_data.tx_byte !== want.tx_byte)
					report_mismatch($sformatf("tx_byte %h, want %h",
						out_data.tx_byte, want.tx_byte));
				if (out_data.chip_select_low !== want.chip_select_low)
					report_mismatch($sformatf("chip_select_low %b, want %b",
						out_data.chip_select_low, want.chip_select_low));
				if (out_data.read_byte !== want.read_byte)
					report_mismatch($sformatf("read_byte %h, want %h",
						out_data.read_byte, want.read_byte));
				if (out_data.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						out_data.status, want.status));
				if (out_data.high_capacity !== want.high_capacity)
					report_mismatch($sformatf("high_capacity %b, want %b",
						out_data.high_capacity, want.high_capacity));
				if (out_data.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run %b, want %b",
						out_data.last_of_run, want.last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	typedef struct {
		in_req_t it;
		int n;
		out_req_t res;
	} row_t;

	row_t rows[$];

	function automatic void add_row(logic [2:0] f, logic [7:0] rx, logic [31:0] addr,
			logic [7:0] wb, int n, out_req_t res);
		row_t rw;
		rw.it = '{func: f, rx_byte: rx, block_addr: addr, wr_byte: wb};
		rw.n = n;
		rw.res = res;
		rows.push_back(rw);
	endfunction

	initial begin
		out_req_t none;
		out_req_t first_bus;
		logic [15:0] cfg_set[PHASES][4];
		int cnt;
		none = '0;
		first_bus = '{kind: KD_BUS, tx_byte: 8'hFF, chip_select_low: 1'b1, read_byte: 8'h00,
			status: S_OK, high_capacity: 1'b0, last_of_run: 1'b1};

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_RESET_RETRY;
		cfg_data = '0;

		cfg_set[1] = '{16'd1, 16'd1, 16'd1, 16'd1};
		cfg_set[2] = '{16'd255, 16'hFFFF, 16'd255, 16'hFFFF};
		cfg_set[3] = '{16'd0, 16'd0, 16'd0, 16'd0};
		for (int p = 4; p < PHASES - 1; p++)
			cfg_set[p] = '{16'($urandom_range(1, 8)), 16'($urandom_range(1, 12)),
				16'($urandom_range(1, 6)), 16'($urandom_range(1, 40))};
		cfg_set[PHASES - 1] = '{16'd200, 16'd3000, 16'd255, 16'hFFFF};

		// ignored requests while idle, then a rejected read and a write up to its first data byte
		add_row(FN_REPLY, 8'hFF, 32'h0, 8'h00, 0, none);
		add_row(FN_RSVD_LO, 8'h00, 32'h0, 8'h00, 0, none);
		add_row(FN_RSVD_HI, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 0, none);
		add_row(FN_WBYTE, 8'h00, 32'h0, 8'hA5, 0, none);
		add_row(FN_READ, 8'h00, 32'hFFFF_FFFF, 8'h00, 1, first_bus);
		add_row(FN_INIT, 8'h00, 32'h0, 8'h00, 0, none);
		for (int i = 0; i < 7; i++)
			add_row(FN_REPLY, 8'h00, 32'h0, 8'h00, -1, none);
		add_row(FN_REPLY, 8'h80, 32'h0, 8'h00, -1, none);
		add_row(FN_REPLY, 8'h7F, 32'h0, 8'h00, -1, none);
		add_row(FN_WRITE, 8'h00, 32'h0, 8'h00, 1, first_bus);
		for (int i = 0; i < 7; i++)
			add_row(FN_REPLY, 8'hFF, 32'h0, 8'h00, -1, none);
		add_row(FN_REPLY, 8'h00, 32'h0, 8'h00, -1, none);
		add_row(FN_REPLY, 8'hFF, 32'h0, 8'h00, -1, none);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			issue(rows[i].it, rows[i].n, rows[i].res);

		// an operation may span phases; limits change only with nothing in flight
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain();
				for (int r = 0; r < 4; r++)
					write_reg(2'(r), cfg_set[p][r]);
			end
			calm = (p == PHASES - 1);
			cnt = 0;
			while (cnt < PHASE_ITEMS) begin
				if (!calm && $urandom_range(0, 15) == 0) begin
					@(negedge clk);
					in_valid <= 1'b0;
					repeat ($urandom_range(0, 10)) @(negedge clk);
				end
				issue(next_request(), -1, none);
				if (step_n > 0)
					cnt++;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (pending_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_q.size()));
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
